// ===== src/pdc_pkg.sv =====
`default_nettype none

package pdc_pkg;

    localparam int GRID_W        = 64;
    localparam int GRID_H        = 64;
    localparam int MAX_POINTS    = 4096;
    localparam int MAX_REACH     = 16;
    localparam int UNIFORM_REACH = 2;

    localparam int COORD_W    = 16;
    localparam int GX_W       = $clog2(GRID_W);
    localparam int GY_W       = $clog2(GRID_H);
    localparam int GRID_DEPTH = GRID_W * GRID_H;
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int REACH_W    = $clog2(MAX_REACH + 1);
    localparam int SHIFT_W    = 4;
    localparam int IDX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PT_W       = 3 * COORD_W;
    localparam int AXIS_W     = (GX_W > GY_W) ? GX_W : GY_W;
    localparam int WIN_W      = ((AXIS_W > REACH_W) ? AXIS_W : REACH_W) + 1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_CLOSE    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_MODE    = 3'd0,
        CFG_BOUND_X        = 3'd1,
        CFG_BOUND_Y        = 3'd2,
        CFG_UNIFORM_RADIUS = 3'd3,
        CFG_CELL_SHIFT     = 3'd4,
        CFG_SEARCH_REACH   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic    load;
        logic    setup;
        logic    scan;
        logic    clear;
        logic    insert;
        logic    emit;
        status_t code;
    } pdc_cmd_t;

    typedef struct packed {
        logic bounds_ok;
        logic last_cell;
        logic busy;
        logic close;
        logic full;
        logic clear_last;
    } pdc_sts_t;

endpackage

`default_nettype wire

// ===== src/poisson_disk_candidate_checker.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata: cand_x, cand_y, cand_radius
// m_axis    out  m_tvalid/m_tready    m_tdata: accepted, status, point_slot, point_count
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// After reset the 4096-cell occupancy grid is swept clear, one cell a cycle:
// no request is taken until the sweep ends.
// An out-of-bounds request is answered right after the bounds check. Otherwise
// the clamped window (5x5 cells for the uniform radius) is scanned, one grid
// read per cycle, into a 5-stage read/distance pipeline that is then drained.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block stalls only when a second result is ready.

module poisson_disk_candidate_checker
    import pdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [47:0]           s_tdata,   // cand_x, cand_y, cand_radius
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // accepted, status[2], point_slot[12],
                                                  // point_count[13], zero pad[4]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    pdc_cmd_t cmd;
    pdc_sts_t sts;

    assign cfg_ready = 1'b1;

    pdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pdc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cand      (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .result    (m_tdata)
    );

    // one request in flight at a time
    a_single_request : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in progress");

    a_insert_legal : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (!sts.full && !sts.close && !sts.busy))
        else $error("insert into full store or after a close hit");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_scan_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan, cmd.insert, cmd.clear, cmd.load}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== src/pdc_ram.sv =====
`default_nettype none

module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/pdc_datapath.sv =====
`default_nettype none

module pdc_datapath
    import pdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [PT_W-1:0]       cand,
    input  wire pdc_cmd_t              cmd,
    output pdc_sts_t                   sts,
    output logic [31:0]                result
);

    // configuration
    logic                 radius_mode_reg;
    logic [COORD_W-1:0]   bound_x_reg;
    logic [COORD_W-1:0]   bound_y_reg;
    logic [COORD_W-1:0]   uniform_radius_reg;
    logic [SHIFT_W-1:0]   cell_shift_reg;
    logic [4:0]           search_reach_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_mode_reg    <= 1'b0;
            bound_x_reg        <= 16'hFFFF;
            bound_y_reg        <= 16'hFFFF;
            uniform_radius_reg <= 16'd16;
            cell_shift_reg     <= 4'd3;
            search_reach_reg   <= 5'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS_MODE:    radius_mode_reg    <= cfg_data[0];
                CFG_BOUND_X:        bound_x_reg        <= cfg_data;
                CFG_BOUND_Y:        bound_y_reg        <= cfg_data;
                CFG_UNIFORM_RADIUS: uniform_radius_reg <= cfg_data;
                CFG_CELL_SHIFT:     cell_shift_reg     <= cfg_data[SHIFT_W-1:0];
                CFG_SEARCH_REACH:   search_reach_reg   <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // candidate
    logic [COORD_W-1:0] x_reg, y_reg, r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= cand[COORD_W-1:0];
            y_reg <= cand[2*COORD_W-1:COORD_W];
            r_reg <= cand[3*COORD_W-1:2*COORD_W];
        end
    end

    // window setup
    logic [COORD_W-1:0] sx, sy;
    logic [GX_W-1:0]    cx_next;
    logic [GY_W-1:0]    cy_next;
    logic [WIN_W-1:0]   reach, cxw, cyw, x0w, x1w, y0w, y1w;

    always_comb
    begin
        sx = x_reg >> cell_shift_reg;
        sy = y_reg >> cell_shift_reg;
        cx_next = (sx > COORD_W'(GRID_W - 1)) ? GX_W'(GRID_W - 1) : sx[GX_W-1:0];
        cy_next = (sy > COORD_W'(GRID_H - 1)) ? GY_W'(GRID_H - 1) : sy[GY_W-1:0];
        if (radius_mode_reg)
        begin
            reach = (search_reach_reg > 5'(MAX_REACH)) ? WIN_W'(MAX_REACH)
                                                       : WIN_W'(search_reach_reg);
        end
        else
        begin
            reach = WIN_W'(UNIFORM_REACH);
        end
        cxw = WIN_W'(cx_next);
        cyw = WIN_W'(cy_next);
        x0w = (cxw > reach) ? cxw - reach : '0;
        y0w = (cyw > reach) ? cyw - reach : '0;
        x1w = (cxw + reach < WIN_W'(GRID_W - 1)) ? cxw + reach : WIN_W'(GRID_W - 1);
        y1w = (cyw + reach < WIN_W'(GRID_H - 1)) ? cyw + reach : WIN_W'(GRID_H - 1);
    end

    logic [GX_W-1:0] cx_reg, gx_reg, x1_reg;
    logic [GY_W-1:0] cy_reg, gy_reg, y0_reg, y1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            x1_reg <= x1w[GX_W-1:0];
            y0_reg <= y0w[GY_W-1:0];
            y1_reg <= y1w[GY_W-1:0];
            gx_reg <= x0w[GX_W-1:0];
            gy_reg <= y0w[GY_W-1:0];
        end
        else if (cmd.scan)
        begin
            if (gy_reg == y1_reg)
            begin
                gy_reg <= y0_reg;
                gx_reg <= gx_reg + 1'b1;
            end
            else
            begin
                gy_reg <= gy_reg + 1'b1;
            end
        end
    end

    // occupancy grid and point store
    logic [CNT_W-1:0]   count_reg;
    logic [GRID_AW-1:0] clr_cnt_reg;
    logic [GRID_AW-1:0] scan_addr, cell_addr, grid_waddr;
    logic [CNT_W-1:0]   grid_wdata, grid_rdata;
    logic               grid_we;
    logic [PT_AW-1:0]   pt_raddr;
    logic [PT_W-1:0]    pt_rdata;

    assign scan_addr = GRID_AW'(gx_reg) * GRID_AW'(GRID_H) + GRID_AW'(gy_reg);
    assign cell_addr = GRID_AW'(cx_reg) * GRID_AW'(GRID_H) + GRID_AW'(cy_reg);

    always_comb
    begin
        grid_we    = cmd.clear | cmd.insert;
        grid_waddr = cmd.clear ? clr_cnt_reg : cell_addr;
        grid_wdata = cmd.clear ? '0 : count_reg + 1'b1;
    end

    pdc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (scan_addr),
        .rdata (grid_rdata)
    );

    pdc_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (count_reg[PT_AW-1:0]),
        .wdata ({r_reg, y_reg, x_reg}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // distance pipeline: grid read, store read, abs diff, squares, compare
    logic v1_reg, v2_reg, v3_reg, v4_reg, close_reg;
    logic hit;
    logic [COORD_W-1:0] px, py, dx_reg, dy_reg, pr_reg;
    logic [2*COORD_W-1:0] dx2_reg, dy2_reg, rr_reg;
    logic [2*COORD_W:0]   d2;

    assign hit      = v1_reg && (grid_rdata != '0) && (grid_rdata <= CNT_W'(MAX_POINTS));
    assign pt_raddr = PT_AW'(grid_rdata - 1'b1);
    assign px       = pt_rdata[COORD_W-1:0];
    assign py       = pt_rdata[2*COORD_W-1:COORD_W];
    assign d2       = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            close_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan;
            v2_reg <= hit;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.setup)
            begin
                close_reg <= 1'b0;
            end
            else if (v4_reg && (d2 < {1'b0, rr_reg}))
            begin
                close_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= (x_reg >= px) ? x_reg - px : px - x_reg;
        dy_reg  <= (y_reg >= py) ? y_reg - py : py - y_reg;
        pr_reg  <= radius_mode_reg ? pt_rdata[3*COORD_W-1:2*COORD_W] : uniform_radius_reg;
        dx2_reg <= dx_reg * dx_reg;
        dy2_reg <= dy_reg * dy_reg;
        rr_reg  <= pr_reg * pr_reg;
    end

    // result register
    logic [31:0] result_reg;
    logic        acc;
    logic [CNT_W-1:0] last_idx;

    assign acc      = (cmd.code == ST_ACCEPTED);
    assign last_idx = count_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= {4'd0, count_reg,
                           acc ? last_idx[IDX_W-1:0] : IDX_W'(0),
                           cmd.code, acc};
        end
    end

    assign result = result_reg;

    always_comb
    begin
        sts.bounds_ok  = (x_reg < bound_x_reg) && (y_reg < bound_y_reg);
        sts.last_cell  = (gx_reg == x1_reg) && (gy_reg == y1_reg);
        sts.busy       = v1_reg | v2_reg | v3_reg | v4_reg;
        sts.close      = close_reg;
        sts.full       = (count_reg >= CNT_W'(MAX_POINTS));
        sts.clear_last = (clr_cnt_reg == GRID_AW'(GRID_DEPTH - 1));
    end

endmodule

`default_nettype wire

// ===== src/pdc_ctrl.sv =====
`default_nettype none

module pdc_ctrl
    import pdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire pdc_sts_t sts,
    output pdc_cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_HOLD  = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.bounds_ok)
                begin
                    code_next  = ST_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_cell)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                begin
                    if (sts.close)
                    begin
                        code_next = ST_CLOSE;
                    end
                    else if (sts.full)
                    begin
                        code_next = ST_FULL;
                    end
                    else
                    begin
                        code_next  = ST_ACCEPTED;
                        cmd.insert = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= ST_ACCEPTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
